@@ sv/rbs_pkg.sv @@
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and constants for the ray versus box slab test.
// Holds the Q16.16 number type, the divider lane record, register indexes
// and the pipeline depth figures.
// ----------------------------------------------------------------------------
package rbs_pkg;

  // Signed Q16.16 number.
  typedef logic signed [31:0] q16_t;

  // Saturation limits of a slab parameter.
  localparam q16_t T_MAX = 32'sh7FFF_FFFF;
  localparam q16_t T_MIN = 32'sh8000_0000;

  // One quotient bit is found per divider stage.
  localparam int DIV_STEPS = 32;

  // Registers in a divider: operand stage, the steps and the saturation stage.
  localparam int SDIV_DEPTH = DIV_STEPS + 2;

  // Registers from input to output: divider, swap stage and output register.
  localparam int PIPE_DEPTH = SDIV_DEPTH + 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  // State of one divide as it moves down the step chain. The dividend's
  // remaining bits leave rq at the top while quotient bits enter at the bottom.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] rq;
    logic [31:0] den;
    logic        neg;
    logic        ovf;
  } div_lane_t;

endpackage

@@ sv/rbs_if.sv @@
// ----------------------------------------------------------------------------
// rbs_if: channel interfaces of the ray versus box slab test.
// Each carries valid, ready and the word of its channel.
// ----------------------------------------------------------------------------

// Ray word: origin and direction in box space.
interface rbs_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

// Result word: hit flag and entry distance.
interface rbs_hit_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] t_enter;

  modport source (output valid, hit, t_enter, input ready);
  modport sink (input valid, hit, t_enter, output ready);
endinterface

// Configuration write word: register index and data.
interface rbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [31:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

@@ sv/ray_box_slab_intersection.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_intersection: ray versus axis-aligned box, slab method.
// A ray accepted at the input passes through 36 register stages, set by the
// one-bit-per-stage divider chain, before its result word appears.
// Throughput: one ray per cycle; the whole pipeline holds while a result is
// stalled at the output. Synchronous active-low reset empties the pipeline
// and clears the box corners to zero.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection
  import rbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rbs_ray_if.sink   in_ch,
  rbs_hit_if.source out_ch,
  rbs_cfg_if.sink   cfg_ch
);

  q16_t                  box_lo_r [3];
  q16_t                  box_hi_r [3];
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  logic                  en;
  q16_t                  org  [3];
  q16_t                  dir  [3];
  q16_t                  t0   [3];
  q16_t                  t1   [3];
  logic                  miss [3];
  q16_t                  enter01;
  q16_t                  enter;
  q16_t                  leave01;
  q16_t                  leave;
  logic                  ok;
  logic                  hit_r;
  logic [30:0]           t_enter_r;
  logic                  hit_nxt;
  logic [30:0]           t_enter_nxt;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        box_lo_r[k] <= '0;
        box_hi_r[k] <= '0;
      end
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_BOX_MIN_X: box_lo_r[0] <= cfg_ch.data;
        REG_BOX_MIN_Y: box_lo_r[1] <= cfg_ch.data;
        REG_BOX_MIN_Z: box_lo_r[2] <= cfg_ch.data;
        REG_BOX_MAX_X: box_hi_r[0] <= cfg_ch.data;
        REG_BOX_MAX_Y: box_hi_r[1] <= cfg_ch.data;
        REG_BOX_MAX_Z: box_hi_r[2] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a result word is waiting at the output.
  assign en          = !(out_ch.valid && !out_ch.ready);
  assign in_ch.ready = en;

  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign org[0] = in_ch.origin_x;
  assign org[1] = in_ch.origin_y;
  assign org[2] = in_ch.origin_z;
  assign dir[0] = in_ch.dir_x;
  assign dir[1] = in_ch.dir_y;
  assign dir[2] = in_ch.dir_z;

  // One slab unit per axis.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_slab u_slab (
      .clk  (clk),
      .en   (en),
      .lo   (box_lo_r[a]),
      .hi   (box_hi_r[a]),
      .org  (org[a]),
      .dir  (dir[a]),
      .t0   (t0[a]),
      .t1   (t1[a]),
      .miss (miss[a])
    );
  end

  // Latest entry, earliest exit and the hit decision.
  always_comb begin
    enter01     = (t0[1] > t0[0]) ? t0[1] : t0[0];
    enter       = (t0[2] > enter01) ? t0[2] : enter01;
    leave01     = (t1[1] < t1[0]) ? t1[1] : t1[0];
    leave       = (t1[2] < leave01) ? t1[2] : leave01;
    ok          = !miss[0] && !miss[1] && !miss[2] && (leave >= enter) && !enter[31];
    hit_nxt     = ok;
    t_enter_nxt = ok ? enter[30:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r     <= hit_nxt;
      t_enter_r <= t_enter_nxt;
    end
  end

  assign out_ch.valid   = vld_r[PIPE_DEPTH-1];
  assign out_ch.hit     = hit_r;
  assign out_ch.t_enter = t_enter_r;

`ifndef ASSERT_OFF
  // A miss always reports a zero distance.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.hit |-> out_ch.t_enter == '0)
    else $error("miss word carries a nonzero distance");

  // No word is taken in while the output is stalled.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while the output is stalled");

  // Reset leaves no result word behind.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result word valid right after reset");
`endif

endmodule

@@ sv/rbs_div_step.sv @@
// ----------------------------------------------------------------------------
// rbs_div_step: one stage of the restoring divider.
// Brings down one dividend bit, subtracts the divisor when it fits and
// records one quotient bit.
// ----------------------------------------------------------------------------
module rbs_div_step
  import rbs_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  div_lane_t lane_i,
  output div_lane_t lane_o
);

  div_lane_t   lane_r;
  div_lane_t   lane_nxt;
  logic [32:0] trial;
  logic        take;

  // Trial subtraction of the divisor from the extended remainder.
  always_comb begin
    trial         = {lane_i.rem, lane_i.rq[31]};
    take          = (trial >= {1'b0, lane_i.den});
    lane_nxt      = lane_i;
    lane_nxt.rq   = {lane_i.rq[30:0], take};
    lane_nxt.rem  = take ? 32'(trial - {1'b0, lane_i.den}) : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

@@ sv/rbs_sdiv.sv @@
// ----------------------------------------------------------------------------
// rbs_sdiv: pipelined signed Q16.16 divide with saturation.
// Computes (num * 65536) / den truncated toward zero, clamped to 32 bits.
// One operand stage, one stage per quotient bit and one saturation stage.
// ----------------------------------------------------------------------------
module rbs_sdiv
  import rbs_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] num,
  input  logic signed [31:0] den,
  output q16_t               quo
);

  logic [32:0] num_mag;
  logic [31:0] den_mag;
  div_lane_t   prep_nxt;
  div_lane_t   lanes [DIV_STEPS+1];
  div_lane_t   prep_r;
  q16_t        quo_r;
  q16_t        quo_nxt;
  logic [31:0] q_mag;

  // Operand magnitudes. A quotient of 2^32 or more saturates whatever its
  // sign, so it is flagged here and only 32 quotient bits are developed.
  always_comb begin
    num_mag       = num[32] ? (~num + 33'd1) : num;
    den_mag       = den[31] ? (~den + 32'd1) : den;
    prep_nxt.rem  = {15'd0, num_mag[32:16]};
    prep_nxt.rq   = {num_mag[15:0], 16'd0};
    prep_nxt.den  = den_mag;
    prep_nxt.neg  = num[32] ^ den[31];
    prep_nxt.ovf  = ({15'd0, num_mag} >= {den_mag, 16'd0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign lanes[0] = prep_r;

  // One quotient bit per stage.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    rbs_div_step u_step (
      .clk    (clk),
      .en     (en),
      .lane_i (lanes[i]),
      .lane_o (lanes[i+1])
    );
  end

  // Apply the sign and clamp to the signed 32-bit range.
  always_comb begin
    q_mag = lanes[DIV_STEPS].rq;
    if (lanes[DIV_STEPS].ovf) begin
      quo_nxt = lanes[DIV_STEPS].neg ? T_MIN : T_MAX;
    end else if (!lanes[DIV_STEPS].neg) begin
      quo_nxt = q_mag[31] ? T_MAX : q16_t'(q_mag);
    end else begin
      quo_nxt = (q_mag > 32'h8000_0000) ? T_MIN : q16_t'(~q_mag + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

@@ sv/rbs_slab.sv @@
// ----------------------------------------------------------------------------
// rbs_slab: entry and exit parameters of one axis slab.
// Divides both face distances by the direction, orders the pair, and
// handles a direction of zero as a parallel slab.
// ----------------------------------------------------------------------------
module rbs_slab
  import rbs_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  q16_t lo,
  input  q16_t hi,
  input  q16_t org,
  input  q16_t dir,
  output q16_t t0,
  output q16_t t1,
  output logic miss
);

  logic signed [32:0] num_lo;
  logic signed [32:0] num_hi;
  q16_t               q_lo;
  q16_t               q_hi;
  q16_t               face_a;
  q16_t               face_b;
  logic               par_nxt;
  logic               inside_nxt;
  logic               par_r    [SDIV_DEPTH];
  logic               inside_r [SDIV_DEPTH];
  q16_t               t0_r;
  q16_t               t1_r;
  logic               miss_r;
  q16_t               t0_nxt;
  q16_t               t1_nxt;
  logic               miss_nxt;

  // Exact 33-bit face distances from the origin.
  assign num_lo = {lo[31], lo} - {org[31], org};
  assign num_hi = {hi[31], hi} - {org[31], org};

  rbs_sdiv u_div_lo (
    .clk (clk),
    .en  (en),
    .num (num_lo),
    .den (dir),
    .quo (q_lo)
  );

  rbs_sdiv u_div_hi (
    .clk (clk),
    .en  (en),
    .num (num_hi),
    .den (dir),
    .quo (q_hi)
  );

  // Parallel slab test, faces taken in either order.
  always_comb begin
    face_a     = (lo < hi) ? lo : hi;
    face_b     = (lo < hi) ? hi : lo;
    par_nxt    = (dir == '0);
    inside_nxt = (org >= face_a) && (org <= face_b);
  end

  // Carry the parallel flags alongside the divides.
  always_ff @(posedge clk) begin
    if (en) begin
      par_r[0]    <= par_nxt;
      inside_r[0] <= inside_nxt;
      for (int k = 1; k < SDIV_DEPTH; k++) begin
        par_r[k]    <= par_r[k-1];
        inside_r[k] <= inside_r[k-1];
      end
    end
  end

  // Order the pair so that entry is not after exit; a parallel slab gets the full range.
  always_comb begin
    miss_nxt = par_r[SDIV_DEPTH-1] && !inside_r[SDIV_DEPTH-1];
    if (par_r[SDIV_DEPTH-1]) begin
      t0_nxt = T_MIN;
      t1_nxt = T_MAX;
    end else if (q_lo > q_hi) begin
      t0_nxt = q_hi;
      t1_nxt = q_lo;
    end else begin
      t0_nxt = q_lo;
      t1_nxt = q_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r   <= t0_nxt;
      t1_r   <= t1_nxt;
      miss_r <= miss_nxt;
    end
  end

  assign t0   = t0_r;
  assign t1   = t1_r;
  assign miss = miss_r;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray versus box slab test bench.
// Sends rays through the block with random idling on both channels, predicts
// result words from its own slab model or takes them typed in by hand, and checks every word in order.
// The box corners are rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench
  import rbs_pkg::*;
;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    logic        hit;
    logic [30:0] t_enter;
  } hit_t;

  // One row of directed stimulus; has_exp marks a result typed in by hand.
  typedef struct {
    ray_t        ray;
    logic        has_exp;
    logic        hit;
    logic [30:0] t_enter;
  } row_t;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam int     DRAIN = PIPE_DEPTH + 10;
  localparam longint LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic failed = 1'b0;
  longint cycles = 0;

  rbs_ray_if ray_ch ();
  rbs_hit_if hit_ch ();
  rbs_cfg_if cfg_ch ();

  ray_box_slab_intersection dut (
    .clk(clk), .rst_n(rst_n), .in_ch(ray_ch.sink), .out_ch(hit_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // Box corners as the testbench believes them.
  logic signed [31:0] corner_lo [3];
  logic signed [31:0] corner_hi [3];

  hit_t pending_hits[$];
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Quotient in Q16.16, truncated toward zero, saturated.
  function automatic longint slab_div(longint n, longint d);
    longint q;
    q = (n * 65536) / d;
    if (q > QMAX) return QMAX;
    if (q < QMIN) return QMIN;
    return q;
  endfunction

  function automatic hit_t predict_hit(ray_t r);
    hit_t   h;
    longint enter, leave, o, d, lo, hi, p, q, s;
    bit     ok;
    enter = QMIN;
    leave = QMAX;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      case (a)
        0: begin o = r.ox; d = r.dx; end
        1: begin o = r.oy; d = r.dy; end
        default: begin o = r.oz; d = r.dz; end
      endcase
      lo = corner_lo[a];
      hi = corner_hi[a];
      if (d == 0) begin
        // Parallel slab: no limit if the origin sits between the faces.
        if (o < ((lo < hi) ? lo : hi) || o > ((lo < hi) ? hi : lo)) ok = 1'b0;
      end else begin
        p = slab_div(lo - o, d);
        q = slab_div(hi - o, d);
        if (p > q) begin s = p; p = q; q = s; end
        if (p > enter) enter = p;
        if (q < leave) leave = q;
      end
    end
    if (leave < enter || enter < 0) ok = 1'b0;
    h.hit = ok;
    h.t_enter = ok ? enter[30:0] : 31'd0;
    return h;
  endfunction

  // Result channel: random stalls, then compare with the oldest expectation.
  always @(posedge clk) begin
    hit_t e;
    if (!rst_n) begin
      hit_ch.ready <= 1'b0;
    end else begin
      if (hit_ch.valid && hit_ch.ready) begin
        if (pending_hits.size() == 0) begin
          $error("unexpected result word hit=%0d t_enter=%0d", hit_ch.hit, hit_ch.t_enter);
          failed = 1'b1;
        end else begin
          e = pending_hits.pop_front();
          if (hit_ch.hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, hit_ch.hit);
            failed = 1'b1;
          end
          if (hit_ch.t_enter !== e.t_enter) begin
            $error("t_enter: expected %0d, got %0d", e.t_enter, hit_ch.t_enter);
            failed = 1'b1;
          end
        end
      end
      hit_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one register write and hold it until taken; valid stays high.
  task automatic write_corner(logic [CFG_IDX_W-1:0] idx, logic signed [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx < REG_BOX_MAX_X) corner_lo[idx] = val;
    else corner_hi[idx - REG_BOX_MAX_X] = val;
  endtask

  task automatic set_box(logic signed [31:0] lx, ly, lz, hx, hy, hz);
    write_corner(REG_BOX_MIN_X, lx);
    write_corner(REG_BOX_MIN_Y, ly);
    write_corner(REG_BOX_MIN_Z, lz);
    write_corner(REG_BOX_MAX_X, hx);
    write_corner(REG_BOX_MAX_Y, hy);
    write_corner(REG_BOX_MAX_Z, hz);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every result has arrived and the pipeline has emptied.
  task automatic drain();
    ray_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Offer one ray with a random idle gap, hold until accepted. Valid stays
  // high afterwards; an idle gap before the next ray or the drain takes it down.
  task automatic send_ray(ray_t r, hit_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      ray_ch.valid <= 1'b0;
      @(posedge clk);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.origin_x <= r.ox;
    ray_ch.origin_y <= r.oy;
    ray_ch.origin_z <= r.oz;
    ray_ch.dir_x <= r.dx;
    ray_ch.dir_y <= r.dy;
    ray_ch.dir_z <= r.dz;
    @(posedge clk);
    while (!ray_ch.ready) @(posedge clk);
    pending_hits = {pending_hits, e};
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh8000_0000 + $urandom_range(3);
      2: return 32'sh7FFF_FFFF - $urandom_range(3);
      3: return 0;
      default: return $signed($urandom_range(2 * 65536 * 40)) - 65536 * 40;
    endcase
  endfunction

  // Mostly rays aimed from outside toward the box, some pure noise.
  function automatic ray_t rand_ray();
    ray_t r;
    r.ox = rand_q(); r.oy = rand_q(); r.oz = rand_q();
    if ($urandom_range(3) != 0) begin
      r.dx = $signed(corner_lo[0]) / 2 + $signed(corner_hi[0]) / 2 - r.ox / 2
             + $signed($urandom_range(65535)) - 32768;
      r.dy = $signed(corner_lo[1]) / 2 + $signed(corner_hi[1]) / 2 - r.oy / 2
             + $signed($urandom_range(65535)) - 32768;
      r.dz = $signed(corner_lo[2]) / 2 + $signed(corner_hi[2]) / 2 - r.oz / 2
             + $signed($urandom_range(65535)) - 32768;
      if ($urandom_range(7) == 0) r.dy = 0;
    end else begin
      r.dx = rand_q(); r.dy = rand_q(); r.dz = rand_q();
    end
    return r;
  endfunction

  task automatic random_rays(int n);
    ray_t r;
    for (int i = 0; i < n; i++) begin
      r = rand_ray();
      send_ray(r, predict_hit(r));
    end
  endtask

  function automatic row_t mk(ray_t r, logic has_exp, logic h, logic [30:0] t);
    row_t w;
    w.ray = r; w.has_exp = has_exp; w.hit = h; w.t_enter = t;
    return w;
  endfunction

  function automatic ray_t rr(int ox, oy, oz, dx, dy, dz);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
    return r;
  endfunction

  localparam int ONE = 65536;

  initial begin
    row_t rows[$];
    hit_t e;
    ray_ch.valid = 1'b0;
    ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
    ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = '0;
    cfg_ch.data = '0;
    hit_ch.ready = 1'b0;
    for (int a = 0; a < 3; a++) begin corner_lo[a] = 0; corner_hi[a] = 0; end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first against the point box left by reset.
    rows = {rows, mk(rr(0, 0, 0, 0, 0, 0), 1, 1'b0, 0)};
    rows = {rows, mk(rr(1, 0, 0, 0, 0, 0), 1, 1'b0, 0)};
    foreach (rows[i]) begin
      e.hit = rows[i].hit; e.t_enter = rows[i].t_enter;
      send_ray(rows[i].ray, e);
    end
    drain();
    rows.delete();

    // Box from 1 to 2 on every axis.
    set_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE);
    // Straight along the diagonal: enters at t = 1.
    rows = {rows, mk(rr(0, 0, 0, ONE, ONE, ONE), 1, 1'b1, ONE)};
    // Origin inside the box is a miss.
    rows = {rows, mk(rr(ONE + ONE / 2, ONE + ONE / 2, ONE + ONE / 2, ONE, 0, 0), 1, 1'b0, 0)};
    // Parallel axes inside the slab, and on a face.
    rows = {rows, mk(rr(0, ONE + 5, 2 * ONE, ONE, 0, 0), 1, 1'b1, ONE)};
    // Parallel axis outside the slab.
    rows = {rows, mk(rr(0, 3 * ONE, ONE, ONE, 0, 0), 1, 1'b0, 0)};
    // Pointing toward the box, then away: entry negative.
    rows = {rows, mk(rr(3 * ONE, ONE + 9, ONE + 9, -ONE, 0, 0), 0, 0, 0)};
    rows = {rows, mk(rr(3 * ONE, ONE + 9, ONE + 9, ONE, 0, 0), 1, 1'b0, 0)};
    // Origin on the face: entry zero is a hit.
    rows = {rows, mk(rr(ONE, ONE + 9, ONE + 9, ONE, 0, 0), 1, 1'b1, 0)};
    // Slab ranges that do not overlap: exit comes before entry.
    rows = {rows, mk(rr(0, ONE, 0, ONE, -ONE, 2 * ONE), 0, 0, 0)};
    // Saturated quotients from tiny directions and extreme origins.
    rows = {rows, mk(rr(32'sh8000_0000, ONE + 1, ONE + 1, 1, 0, 0), 0, 0, 0)};
    rows = {rows, mk(rr(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000), 0, 0, 0)};
    rows = {rows, mk(rr(-1, -1, -1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF),
                     0, 0, 0)};
    rows = {rows, mk(rr(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1, 1, 1),
                     0, 0, 0)};
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        e.hit = rows[i].hit; e.t_enter = rows[i].t_enter;
      end else begin
        e = predict_hit(rows[i].ray);
      end
      send_ray(rows[i].ray, e);
    end
    drain();
    rows.delete();

    // Swapped corners and an extreme box.
    set_box(2 * ONE, 32'sh7FFF_FFFF, -ONE, -2 * ONE, 32'sh8000_0000, ONE);
    rows = {rows, mk(rr(-5 * ONE, 7, 0, ONE, 0, 0), 0, 0, 0)};
    rows = {rows, mk(rr(-5 * ONE, 7, 3 * ONE, 0, 0, -ONE), 0, 0, 0)};
    rows = {rows, mk(rr(-5 * ONE, 7, 3 * ONE, ONE, 3, -ONE), 0, 0, 0)};
    foreach (rows[i]) send_ray(rows[i].ray, predict_hit(rows[i].ray));

    // Random phases with different idling and boxes.
    send_idle_pct = 25; recv_idle_pct = 57;
    drain();
    set_box(-4 * ONE, -3 * ONE, -ONE, 5 * ONE, 2 * ONE, 6 * ONE);
    random_rays(270);
    // Hold off the sender until the pipeline has fully emptied.
    drain();
    random_rays(30);
    drain();
    send_idle_pct = 57; recv_idle_pct = 25;
    set_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    random_rays(150);
    drain();
    set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_rays(100);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_box(10 * ONE, -20 * ONE, 3 * ONE, 12 * ONE, -15 * ONE, 30 * ONE);
    random_rays(250);

    drain();
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
